[sv/row_softmax_defines.svh]
// Assertion macros used by the row_softmax RTL
`ifndef ROW_SOFTMAX_DEFINES_SVH
`define ROW_SOFTMAX_DEFINES_SVH

`ifndef ASSERT_OFF
// check prop at each edge outside reset
`define RS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("row_softmax assertion failed");
// check prop at each edge, reset included
`define RS_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
    else $error("row_softmax reset assertion failed");
`else
`define RS_ASSERT(lbl, prop)
`define RS_ASSERT_RST(lbl, prop)
`endif

`endif

[sv/rs_pkg.sv]
package rs_pkg;

    localparam int MAX_COLS_DEF    = 64;
    localparam int SCORE_WIDTH_DEF = 16;
    localparam int PROB_W          = 16;
    localparam int FRAC_STEPS      = 16;
    localparam int INV_W           = 23;
    localparam int NUM_W           = 39;
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;

    typedef logic [29:0] pow_tab_t [FRAC_STEPS];

    function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] bitv;
        n    = n_in;
        res  = '0;
        bitv = 64'd1 << 62;
        for (int k = 0; k < 32; k++)
        begin
            if (n >= res + bitv)
            begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // c_i = 2^(-2^-(i+1)) in Q0.30
    function automatic pow_tab_t build_tab();
        pow_tab_t    tab;
        logic [63:0] c;
        c = isqrt64(64'd1 << 59);
        tab[0] = c[29:0];
        for (int i = 1; i < FRAC_STEPS; i++)
        begin
            c = isqrt64(c << 30);
            tab[i] = c[29:0];
        end
        return tab;
    endfunction

    localparam pow_tab_t POW_TAB = build_tab();

endpackage

[sv/rs_exp.sv]
module rs_exp #(
    parameter int SCORE_WIDTH = rs_pkg::SCORE_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [SCORE_WIDTH:0]   t,
    output logic                   done,
    output logic [rs_pkg::PROB_W-1:0] e
);
    localparam int T_W = SCORE_WIDTH + 1;
    localparam int U_W = T_W + 17;

    localparam logic [1:0] EX_IDLE = 2'd0;
    localparam logic [1:0] EX_MUL  = 2'd1;
    localparam logic [1:0] EX_ITER = 2'd2;
    localparam logic [1:0] EX_FIN  = 2'd3;

    logic [1:0]     state_reg, state_next;
    logic [3:0]     step_reg, step_next;
    logic [T_W-1:0] t_reg;
    logic [U_W-1:0] u_reg;
    logic [30:0]    r_reg, r_next;
    logic           done_reg;
    logic [rs_pkg::PROB_W-1:0] e_reg, e_next;

    logic [15:0]  fvec;
    logic [60:0]  prod;
    logic [60:0]  prod_rnd;
    logic [U_W-1:0] kf;
    logic [4:0]   k5;
    logic         kbig;
    logic [31:0]  e_w;

    assign fvec     = u_reg[23:8];
    assign prod     = 61'(r_reg) * 61'(rs_pkg::POW_TAB[step_reg]);
    assign prod_rnd = prod + (61'(1) << 29);
    assign kf       = u_reg >> 24;
    assign k5       = kf[4:0];
    assign kbig     = kf >= U_W'(17);
    assign e_w      = (32'(r_reg) + (32'(1) << (k5 + 5'd13))) >> (k5 + 5'd14);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        r_next     = r_reg;
        e_next     = e_reg;
        unique case (state_reg)
            EX_IDLE:
            begin
                if (start)
                    state_next = EX_MUL;
            end
            EX_MUL:
            begin
                r_next     = 31'(1) << 30;
                step_next  = '0;
                state_next = EX_ITER;
            end
            EX_ITER:
            begin
                if (fvec[4'd15 - step_reg])
                    r_next = prod_rnd[60:30];
                step_next = step_reg + 4'd1;
                if (step_reg == 4'd15)
                    state_next = EX_FIN;
            end
            EX_FIN:
            begin
                if (kbig)
                    e_next = '0;
                else if (|e_w[31:16])
                    e_next = '1;
                else
                    e_next = e_w[15:0];
                state_next = EX_IDLE;
            end
            default: state_next = EX_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= EX_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == EX_FIN);
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        r_reg    <= r_next;
        e_reg    <= e_next;
        if (state_reg == EX_IDLE && start)
            t_reg <= t;
        if (state_reg == EX_MUL)
            u_reg <= U_W'(t_reg) * U_W'(rs_pkg::LOG2E_Q16);
    end

    assign done = done_reg;
    assign e    = e_reg;
endmodule

[sv/rs_div.sv]
module rs_div #(
    parameter int SUM_W = 22
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [SUM_W-1:0]         sum,
    output logic                     done,
    output logic [rs_pkg::INV_W-1:0] inv
);
    localparam int NW = rs_pkg::NUM_W;

    logic             run_reg;
    logic             done_reg;
    logic [5:0]       cnt_reg;
    logic [SUM_W-1:0] d_reg;
    logic [NW-1:0]    num_reg;
    logic [SUM_W:0]   rem_reg;
    logic [rs_pkg::INV_W-1:0] q_reg;
    logic [SUM_W:0]   rem_sh;
    logic             fits;

    // remainder stays below the divisor, so its low SUM_W bits carry it
    assign rem_sh = {rem_reg[SUM_W-1:0], num_reg[NW-1]};
    assign fits   = rem_sh >= {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !run_reg)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(NW - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !run_reg)
        begin
            d_reg   <= sum;
            num_reg <= (NW'(1) << (NW - 1)) + NW'(sum >> 1);
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (run_reg)
        begin
            num_reg <= num_reg << 1;
            rem_reg <= fits ? rem_sh - {1'b0, d_reg} : rem_sh;
            q_reg   <= {q_reg[rs_pkg::INV_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign inv  = q_reg;
endmodule

[sv/row_softmax.sv]
// Row softmax: scores stream in one beat per cycle while the row loads.
// After the last beat of a row with n stored elements: per element a read,
// a setup state and the iterative exp unit, then the bit-serial reciprocal,
// then per output beat a read, a multiply and the output state.
// Output beats wait on m_tready; no input is taken until the row is drained.
// rst_n clears control state asynchronously; the row memories are not cleared.
`include "row_softmax_defines.svh"

module row_softmax #(
    parameter int MAX_COLS    = rs_pkg::MAX_COLS_DEF,
    parameter int SCORE_WIDTH = rs_pkg::SCORE_WIDTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    input  logic [((SCORE_WIDTH + 7) / 8) * 8 - 1:0] s_tdata, // score
    input  logic s_tlast,                                     // row_end
    output logic m_tvalid,
    input  logic m_tready,
    output logic [rs_pkg::PROB_W-1:0] m_tdata,                // probability
    output logic m_tlast                                      // last_out
);
    localparam int CNT_W = $clog2(MAX_COLS + 1);
    localparam int AW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int SUM_W = $clog2(MAX_COLS * 65535 + 1);
    localparam int PW    = rs_pkg::PROB_W;
    localparam int MW    = PW + rs_pkg::INV_W;

    localparam logic [3:0] ST_LOAD  = 4'd0;
    localparam logic [3:0] ST_P1_RD = 4'd1;
    localparam logic [3:0] ST_P1_GO = 4'd2;
    localparam logic [3:0] ST_P1_WT = 4'd3;
    localparam logic [3:0] ST_DIV   = 4'd4;
    localparam logic [3:0] ST_DV_WT = 4'd5;
    localparam logic [3:0] ST_P2_RD = 4'd6;
    localparam logic [3:0] ST_P2_MU = 4'd7;
    localparam logic [3:0] ST_P2_OUT = 4'd8;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic signed [SCORE_WIDTH-1:0] max_reg, max_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [rs_pkg::INV_W-1:0] inv_reg;
    logic             valid_reg, valid_next;
    logic             last_reg, last_next;
    logic [PW-1:0]    prob_reg, prob_next;

    logic signed [SCORE_WIDTH-1:0] row_mem [MAX_COLS];
    logic [PW-1:0]                 e_mem   [MAX_COLS];
    logic signed [SCORE_WIDTH-1:0] row_rd_reg;
    logic [PW-1:0]                 e_rd_reg;

    logic signed [SCORE_WIDTH-1:0] x;
    logic       in_acc;
    logic       room;
    logic [SCORE_WIDTH:0] t;
    logic       exp_start;
    logic       exp_done;
    logic [PW-1:0] exp_e;
    logic       div_start;
    logic       div_done;
    logic [rs_pkg::INV_W-1:0] div_inv;
    logic [MW-1:0] pm;
    logic [MW-1:0] pm_rnd;

    assign x      = s_tdata[SCORE_WIDTH-1:0];
    assign s_tready = (state_reg == ST_LOAD);
    assign in_acc = s_tvalid && s_tready;
    assign room   = cnt_reg < CNT_W'(MAX_COLS);
    assign t      = (SCORE_WIDTH + 1)'(max_reg) - (SCORE_WIDTH + 1)'(row_rd_reg);
    assign exp_start = (state_reg == ST_P1_GO);
    assign div_start = (state_reg == ST_DIV);
    assign pm     = MW'(e_rd_reg) * MW'(inv_reg);
    assign pm_rnd = pm + (MW'(1) << 21);

    rs_exp #(.SCORE_WIDTH(SCORE_WIDTH)) u_exp (
        .clk   (clk),
        .rst_n (rst_n),
        .start (exp_start),
        .t     (t),
        .done  (exp_done),
        .e     (exp_e)
    );

    rs_div #(.SUM_W(SUM_W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .sum   (sum_reg),
        .done  (div_done),
        .inv   (div_inv)
    );

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        j_next     = j_reg;
        max_next   = max_reg;
        sum_next   = sum_reg;
        valid_next = valid_reg;
        last_next  = last_reg;
        prob_next  = prob_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_acc)
                begin
                    if (room)
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                        if (x > max_reg)
                            max_next = x;
                    end
                    if (s_tlast)
                    begin
                        j_next     = '0;
                        state_next = ST_P1_RD;
                    end
                end
            end
            ST_P1_RD: state_next = ST_P1_GO;
            ST_P1_GO: state_next = ST_P1_WT;
            ST_P1_WT:
            begin
                if (exp_done)
                begin
                    sum_next = sum_reg + SUM_W'(exp_e);
                    if (j_reg + CNT_W'(1) == cnt_reg)
                    begin
                        j_next     = '0;
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        j_next     = j_reg + CNT_W'(1);
                        state_next = ST_P1_RD;
                    end
                end
            end
            ST_DIV:   state_next = ST_DV_WT;
            ST_DV_WT:
            begin
                if (div_done)
                    state_next = ST_P2_RD;
            end
            ST_P2_RD: state_next = ST_P2_MU;
            ST_P2_MU:
            begin
                prob_next  = (|pm_rnd[MW-1:22 + PW]) ? '1 : pm_rnd[22 + PW - 1:22];
                last_next  = (j_reg + CNT_W'(1) == cnt_reg);
                valid_next = 1'b1;
                state_next = ST_P2_OUT;
            end
            ST_P2_OUT:
            begin
                if (m_tready)
                begin
                    valid_next = 1'b0;
                    if (last_reg)
                    begin
                        cnt_next   = '0;
                        sum_next   = '0;
                        max_next   = {1'b1, {(SCORE_WIDTH - 1){1'b0}}};
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        j_next     = j_reg + CNT_W'(1);
                        state_next = ST_P2_RD;
                    end
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            j_reg     <= '0;
            max_reg   <= {1'b1, {(SCORE_WIDTH - 1){1'b0}}};
            sum_reg   <= '0;
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            j_reg     <= j_next;
            max_reg   <= max_next;
            sum_reg   <= sum_next;
            valid_reg <= valid_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prob_reg <= prob_next;
        if (div_done)
            inv_reg <= div_inv;
        if (in_acc && room)
            row_mem[cnt_reg[AW-1:0]] <= x;
        row_rd_reg <= row_mem[j_reg[AW-1:0]];
        if (state_reg == ST_P1_WT && exp_done)
            e_mem[j_reg[AW-1:0]] <= exp_e;
        e_rd_reg <= e_mem[j_reg[AW-1:0]];
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = prob_reg;
    assign m_tlast  = last_reg;

    `RS_ASSERT(a_valid_in_out, m_tvalid |-> (state_reg == ST_P2_OUT))
    `RS_ASSERT(a_cnt_bound, cnt_reg <= CNT_W'(MAX_COLS))
    `RS_ASSERT(a_last_clears, (m_tvalid && m_tready && m_tlast) |=> (s_tready && cnt_reg == '0))
    `RS_ASSERT(a_exp_done_wait, exp_done |-> (state_reg == ST_P1_WT))
    `RS_ASSERT_RST(a_rst_quiet, !rst_n |-> !m_tvalid)
endmodule
